/* rtl/tws_pkg.sv */
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants
// Widths, state codes and status structs used by the smoothing filter.
// ----------------------------------------------------------------------------
package tws_pkg;

  // Largest supported half width and sample width
  localparam int MAX_HALF    = 15;
  localparam int SAMPLE_BITS = 16;

  // Derived sizes
  localparam int HIST_DEPTH = 2 * MAX_HALF + 1;
  localparam int HW_BITS    = $clog2(MAX_HALF + 1);
  localparam int W_BITS     = HW_BITS + 1;
  localparam int PROD_W     = SAMPLE_BITS + W_BITS + 1;
  localparam int DIV_W      = 2 * HW_BITS + 1;
  localparam int ACC_W      = SAMPLE_BITS + 2 * HW_BITS;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int STEP_W     = $clog2(HIST_DEPTH);
  localparam int DCNT_W     = $clog2(ACC_W);

  // Configuration port
  localparam int CFG_W  = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [0:0]       REG_HALF_WIDTH = 1'b0;
  localparam logic [CFG_W-1:0] HALF_WIDTH_RST = 4'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_DSTART,
    ST_DIV,
    ST_MAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/tws_cell.sv */
// ----------------------------------------------------------------------------
// tws_cell: one history cell
// Holds one sample and passes it to the next cell when the chain moves.
// ----------------------------------------------------------------------------
module tws_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tws_pkg::sample_t  din,
  output tws_pkg::sample_t  dout
);
  import tws_pkg::*;

  sample_t q_r;

  // Clear on reset, take the neighbor's sample when the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= din;
    end
  end

  assign dout = q_r;

endmodule

/* rtl/tws_div.sv */
// ----------------------------------------------------------------------------
// tws_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tws_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tws_pkg::ACC_W-1:0]     dividend,
  input  logic [tws_pkg::DIV_W-1:0]     divisor,
  output logic [tws_pkg::ACC_W-1:0]     quotient,
  output tws_pkg::div_stat_t            stat
);
  import tws_pkg::*;

  logic [DIV_W-1:0]  rem_r;
  logic [ACC_W-1:0]  quo_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              qbit;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[ACC_W-1]};
    diff    = shifted - {1'b0, divisor};
    qbit    = ~diff[DIV_W];
  end

  // Control: busy until all ACC_W quotient bits are shifted in, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_r <= {quo_r[ACC_W-2:0], qbit};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/triangular_weighted_smoothing_filter_top.sv */
// ----------------------------------------------------------------------------
// triangular_weighted_smoothing_filter_top: triangular moving average
// Centered weighted average over 2h+1 samples with weights 1..h+1..1,
// divided by (h+1)^2 and truncated toward zero; edge outputs are zero.
// ----------------------------------------------------------------------------
// Flow: an edge or flush result enters the output register from the MAIN or
//   FLUSH state once the output is free; a computed result first passes the
//   rotation around the history cells, the divider start, the divide steps
//   and the done pulse, then the output load. in_stall holds the input until
//   all results of an item are loaded, and output stalls hold the MAIN and
//   FLUSH states; an item that produces no result leaves the filter idle.
// Reset: counters clear, half_width returns to 2; history cells clear to 0.
// ----------------------------------------------------------------------------
module triangular_weighted_smoothing_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tws_pkg::sample_t              in_sample,
  input  logic                          in_last_sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output tws_pkg::sample_t              out_smoothed,
  output logic                          out_edge_zero,
  output logic                          out_final_output,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tws_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [tws_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [tws_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import tws_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     half_width_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [STEP_W-1:0]    step_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [HW_BITS-1:0]   h_r;
  logic                 edge_main_r;
  logic                 fin_main_r;
  logic [HW_BITS-1:0]   rest_r;

  logic                 out_valid_r;
  sample_t              smoothed_r;
  logic                 edge_r;
  logic                 fin_r;

  sample_t              cell_q [HIST_DEPTH];
  sample_t              chain_din;
  logic                 shift_en;

  logic                 cfg_wr;
  logic                 accept;
  logic [HW_BITS-1:0]   h_cur;
  logic                 a_main;
  logic                 a_edge;
  logic [HW_BITS-1:0]   a_rest;
  logic                 rot_last;
  logic                 out_free;
  logic                 load_main;
  logic                 load_flush;
  logic                 div_start;

  logic [STEP_W-1:0]    tap_k;
  logic [STEP_W-1:0]    h_ext;
  logic [STEP_W-1:0]    tap_dist;
  logic [STEP_W-1:0]    w_full;
  logic [W_BITS-1:0]    w;
  logic signed [PROD_W-1:0] prod;

  logic [W_BITS-1:0]    hp1;
  logic [2*W_BITS-1:0]  hsq;
  logic [ACC_W-1:0]     acc_mag;
  logic [ACC_W-1:0]     quotient;
  div_stat_t            div_st;
  sample_t              q_lo;
  sample_t              main_val;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[ADDR_W-1:2] == REG_HALF_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
    end else if (cfg_wr) begin
      half_width_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[ADDR_W-1:2] == REG_HALF_WIDTH) begin
      cfg_prdata = {{(DATA_W-CFG_W){1'b0}}, half_width_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // Clamp the half width to MAX_HALF so the window fits the history depth
  assign h_cur = (half_width_r > CFG_W'(MAX_HALF)) ? HW_BITS'(MAX_HALF)
                                                   : HW_BITS'(half_width_r);

  // --------------------------------------------------------------------------
  // Item decode at acceptance
  // --------------------------------------------------------------------------
  assign accept = in_valid && (state_r == ST_IDLE);

  always_comb begin
    a_main = (cnt_r >= CNT_W'(h_cur));
    a_edge = (cnt_r < CNT_W'({h_cur, 1'b0}));
    if (!in_last_sample) begin
      a_rest = '0;
    end else if (cnt_r < CNT_W'(h_cur)) begin
      a_rest = HW_BITS'(cnt_r + CNT_W'(1));
    end else begin
      a_rest = h_cur;
    end
  end

  assign rot_last = (step_r == STEP_W'(HIST_DEPTH - 1));
  assign out_free = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // State machine: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (a_main) begin
            state_nxt = a_edge ? ST_MAIN : ST_ROT;
          end else if (a_rest != '0) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_ROT: begin
        if (rot_last) begin
          state_nxt = ST_DSTART;
        end
      end
      ST_DSTART: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_nxt = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (out_free) begin
          state_nxt = (rest_r != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free && (rest_r == HW_BITS'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State machine: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    shift_en   = accept || (state_r == ST_ROT);
    chain_din  = (state_r == ST_ROT) ? cell_q[HIST_DEPTH-1] : in_sample;
    div_start  = (state_r == ST_DSTART);
    load_main  = (state_r == ST_MAIN) && out_free;
    load_flush = (state_r == ST_FLUSH) && out_free;
  end

  // --------------------------------------------------------------------------
  // History cells: shift in on accept, rotate during the weighted pass
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tws_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift_en),
        .din   (chain_din),
        .dout  (cell_q[i])
      );
    end else begin : g_body
      tws_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift_en),
        .din   (cell_q[i-1]),
        .dout  (cell_q[i])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Tap weight: head cell holds sample k at pass step s (k = 0, 30, 29, ..)
  // --------------------------------------------------------------------------
  always_comb begin
    tap_k    = (step_r == '0) ? '0 : (STEP_W'(HIST_DEPTH) - step_r);
    h_ext    = STEP_W'(h_r);
    tap_dist = (tap_k > h_ext) ? (tap_k - h_ext) : (h_ext - tap_k);
    w_full   = h_ext + STEP_W'(1) - tap_dist;
    if (tap_k <= STEP_W'({h_r, 1'b0})) begin
      w = W_BITS'(w_full);
    end else begin
      w = '0;
    end
    prod = PROD_W'(cell_q[0] * $signed({1'b0, w}));
  end

  // --------------------------------------------------------------------------
  // Divide by (h+1)^2 on the magnitude, then restore the sign
  // --------------------------------------------------------------------------
  always_comb begin
    hp1     = {1'b0, h_r} + W_BITS'(1);
    hsq     = hp1 * hp1;
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    q_lo    = sample_t'(quotient[SAMPLE_BITS-1:0]);
    main_val = acc_r[ACC_W-1] ? sample_t'(-q_lo) : q_lo;
  end

  tws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (DIV_W'(hsq)),
    .quotient (quotient),
    .stat     (div_st)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
      rest_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // count samples of the block, saturating; clear at block end
      if (accept) begin
        if (in_last_sample) begin
          cnt_r <= '0;
        end else if (cnt_r != '1) begin
          cnt_r <= cnt_r + 1'b1;
        end
        rest_r <= a_rest;
        step_r <= '0;
      end else begin
        if (state_r == ST_ROT) begin
          step_r <= step_r + 1'b1;
        end
        if (load_flush) begin
          rest_r <= rest_r - 1'b1;
        end
      end
    end
  end

  // Item attributes and accumulator
  always_ff @(posedge clk) begin
    if (accept) begin
      h_r         <= h_cur;
      edge_main_r <= a_edge;
      fin_main_r  <= in_last_sample && (h_cur == '0);
      acc_r       <= '0;
    end else if (state_r == ST_ROT) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_main || load_flush) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      smoothed_r <= edge_main_r ? '0 : main_val;
      edge_r     <= edge_main_r;
      fin_r      <= fin_main_r;
    end else if (load_flush) begin
      smoothed_r <= '0;
      edge_r     <= 1'b1;
      fin_r      <= (rest_r == HW_BITS'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_smoothed     = smoothed_r;
  assign out_edge_zero    = edge_r;
  assign out_final_output = fin_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_edge_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && edge_r |-> smoothed_r == '0)
    else $error("edge item carries a nonzero value");

  a_final_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fin_r && !edge_r |-> h_r == '0)
    else $error("final computed item with nonzero half width");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_flush_has_rest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |-> rest_r != '0)
    else $error("flush state with no items left");

  a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !load_main && !load_flush)
    else $error("output register loaded while its item is stalled");

endmodule
